>>> design/i2cms_pkg.sv
// shared types and constants for the two-bus i2c master line sequencer
// no dependencies; used by i2cms_step and i2c_master_bit_sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  localparam int NUM_BUSES = 2;
  localparam logic [3:0] BUS_LIMIT = 4'(NUM_BUSES);
  localparam logic [7:0] SHIFT_MSB = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_STOP   = 3'd1,
    OP_SEND   = 3'd2,
    OP_RXBYTE = 3'd3,
    OP_SACK   = 3'd4,
    OP_RXACK  = 3'd5,
    OP_SAMPLE = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_RXBYTE = 2'd1,
    PEND_RXACK  = 2'd2
  } pend_t;

  typedef struct packed {
    logic [2:0] operation;
    logic       bus;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       bus_out;
    logic       scl_level;
    logic       sda_level;
    logic       sample_request;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
    logic       last;
  } out_t;

  // sequencer state carried between commands
  typedef struct packed {
    pend_t      pending;
    logic       active_bus;
    logic [3:0] bit_index;
    logic [7:0] shift_in;
  } ctl_t;

  // everything one pin step decides
  typedef struct packed {
    logic       emit;
    logic       fin;
    logic       wr_scl;
    logic       wr_sda;
    logic       lvl;
    logic       bus;
    out_t       res;
    ctl_t       ctl_nxt;
    logic [1:0] phase_nxt;
    logic [2:0] bitc_nxt;
  } step_t;

endpackage

`default_nettype wire

>>> design/i2c_master_bit_sequencer.sv
// top level of the two-bus i2c master line sequencer: command register, step counters,
// line state and result register; depends on i2cms_pkg and i2cms_step
//
//   port group   dir   payload       handshake
//   in_*         in    i2cms_pkg::in_t   in_valid / in_ready
//   out_*        out   i2cms_pkg::out_t  out_valid / out_ready
//
// one result per cycle while out_ready does not stall; a command makes as many results as it
// has pin writes (1 to 24, send byte is the longest at 24), an ignored item gives nothing
// the step counters in front of i2cms_step set this pace
// the next command is taken in the cycle its last write enters the result register
// reset (synchronous, rst_n low) releases both lines of every bus, clears pending waits
// a stalled out_ready holds the result register and freezes the sequence at its next pin write
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer (
  input  var logic            clk,
  input  var logic            rst_n,
  input  var logic            in_valid,
  output logic                in_ready,
  input  var i2cms_pkg::in_t  in_data,
  output logic                out_valid,
  input  var logic            out_ready,
  output i2cms_pkg::out_t     out_data
);

  logic                              cmd_valid_r, cmd_valid_nxt;
  i2cms_pkg::in_t                    cmd_r, cmd_nxt;
  logic [1:0]                        phase_r, phase_nxt;
  logic [2:0]                        bitc_r, bitc_nxt;
  i2cms_pkg::ctl_t                   ctl_r, ctl_nxt;
  logic [i2cms_pkg::NUM_BUSES-1:0]   scl_r, scl_nxt;
  logic [i2cms_pkg::NUM_BUSES-1:0]   sda_r, sda_nxt;
  logic                              out_valid_r, out_valid_nxt;
  i2cms_pkg::out_t                   out_r, out_nxt;

  i2cms_pkg::step_t st;
  logic             out_free;
  logic             advance;
  logic             in_fire;
  logic             put;

  i2cms_step u_step (
    .cmd   (cmd_r),
    .phase (phase_r),
    .bitc  (bitc_r),
    .ctl   (ctl_r),
    .scl_v (scl_r),
    .sda_v (sda_r),
    .st    (st)
  );

  assign out_free = !out_valid_r || out_ready;
  assign advance  = cmd_valid_r && (!st.emit || out_free);
  assign put      = advance && st.emit;
  assign in_ready = !cmd_valid_r || (advance && st.fin);
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    bitc_nxt      = bitc_r;
    ctl_nxt       = ctl_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (advance) begin
      ctl_nxt = st.ctl_nxt;
      if (st.fin) begin
        cmd_valid_nxt = 1'b0;
        phase_nxt     = 2'd0;
        bitc_nxt      = 3'd0;
      end else begin
        phase_nxt = st.phase_nxt;
        bitc_nxt  = st.bitc_nxt;
      end
    end
    if (in_fire) begin
      cmd_valid_nxt = 1'b1;
      cmd_nxt       = in_data;
    end

    if (put) begin
      if (st.wr_scl) scl_nxt[st.bus] = st.lvl;
      if (st.wr_sda) sda_nxt[st.bus] = st.lvl;
      out_valid_nxt = 1'b1;
      out_nxt       = st.res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r        <= 1'b0;
      phase_r            <= 2'd0;
      bitc_r             <= 3'd0;
      ctl_r.pending      <= i2cms_pkg::PEND_NONE;
      ctl_r.active_bus   <= 1'b0;
      ctl_r.bit_index    <= 4'd0;
      ctl_r.shift_in     <= 8'h00;
      scl_r              <= '1;
      sda_r              <= '1;
      out_valid_r        <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      phase_r     <= phase_nxt;
      bitc_r      <= bitc_nxt;
      ctl_r       <= ctl_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // a sample request always leaves the sequencer waiting
  a_req_pending : assert property (@(posedge clk) disable iff (!rst_n)
    put && st.res.sample_request |=> ctl_r.pending != i2cms_pkg::PEND_NONE)
    else $error("sample request issued without a pending wait");

  // done only ever closes a transfer group
  a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> out_r.last)
    else $error("done result not marked last");

  a_byte_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.read_byte != 8'h00) |-> out_r.done_res)
    else $error("read byte shown outside a finished receive");

  a_bit_range : assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.bit_index <= i2cms_pkg::BITS_PER_BYTE)
    else $error("bit index ran past one byte");

  // no new command is taken while one is mid sequence
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid_r && !(advance && st.fin) |-> !in_ready)
    else $error("command register overrun");
`endif

endmodule

`default_nettype wire

>>> design/i2cms_step.sv
// pin step decoder: at most one bus write per call from command, step counters and line state
// depends on i2cms_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cms_step (
  input  var i2cms_pkg::in_t                      cmd,
  input  var logic [1:0]                          phase,
  input  var logic [2:0]                          bitc,
  input  var i2cms_pkg::ctl_t                     ctl,
  input  var logic [i2cms_pkg::NUM_BUSES-1:0]     scl_v,
  input  var logic [i2cms_pkg::NUM_BUSES-1:0]     sda_v,
  output i2cms_pkg::step_t                        st
);

  i2cms_pkg::op_t op;
  logic           drop;
  logic [3:0]     bi_new;
  logic [7:0]     sh_new;

  assign op     = i2cms_pkg::op_t'(cmd.operation);
  assign bi_new = ctl.bit_index + 4'd1;
  assign sh_new = ctl.shift_in |
                  ((cmd.sda_sample && (ctl.bit_index < i2cms_pkg::BITS_PER_BYTE))
                   ? (i2cms_pkg::SHIFT_MSB >> ctl.bit_index[2:0]) : 8'h00);

  always_comb begin
    st           = '0;
    st.fin       = 1'b1;
    st.bus       = cmd.bus;
    st.ctl_nxt   = ctl;
    st.phase_nxt = phase + 2'd1;
    st.bitc_nxt  = bitc;
    drop         = 1'b0;

    if (op == i2cms_pkg::OP_SAMPLE) begin
      st.bus = ctl.active_bus;
      drop   = (ctl.pending == i2cms_pkg::PEND_NONE) ||
               ({3'b000, ctl.active_bus} >= i2cms_pkg::BUS_LIMIT);
    end else begin
      drop = (ctl.pending != i2cms_pkg::PEND_NONE) ||
             ({3'b000, cmd.bus} >= i2cms_pkg::BUS_LIMIT);
    end

    if (!drop) begin
      st.emit = 1'b1;
      unique case (op) inside
        i2cms_pkg::OP_START: begin
          st.fin = (phase == 2'd3);
          case (phase)
            2'd0:    begin st.wr_sda = 1'b1; st.lvl = 1'b1; end
            2'd1:    begin st.wr_scl = 1'b1; st.lvl = 1'b1; end
            2'd2:    begin st.wr_sda = 1'b1; st.lvl = 1'b0; end
            default: begin st.wr_scl = 1'b1; st.lvl = 1'b0; end
          endcase
          st.res.done_res = st.fin;
        end
        i2cms_pkg::OP_STOP: begin
          st.fin = (phase == 2'd2);
          case (phase)
            2'd0:    begin st.wr_sda = 1'b1; st.lvl = 1'b0; end
            2'd1:    begin st.wr_scl = 1'b1; st.lvl = 1'b1; end
            default: begin st.wr_sda = 1'b1; st.lvl = 1'b1; end
          endcase
          st.res.done_res = st.fin;
        end
        i2cms_pkg::OP_SEND: begin
          // three writes per bit, msb first
          st.fin = (phase == 2'd2) && (bitc == 3'd7);
          case (phase)
            2'd0:    begin st.wr_sda = 1'b1; st.lvl = cmd.write_data[3'd7 - bitc]; end
            2'd1:    begin st.wr_scl = 1'b1; st.lvl = 1'b1; end
            default: begin
              st.wr_scl    = 1'b1;
              st.lvl       = 1'b0;
              st.phase_nxt = 2'd0;
              st.bitc_nxt  = bitc + 3'd1;
            end
          endcase
          st.res.done_res = st.fin;
        end
        i2cms_pkg::OP_SACK: begin
          st.fin = (phase == 2'd2);
          case (phase)
            2'd0:    begin st.wr_sda = 1'b1; st.lvl = cmd.ack_to_send; end
            2'd1:    begin st.wr_scl = 1'b1; st.lvl = 1'b1; end
            default: begin st.wr_scl = 1'b1; st.lvl = 1'b0; end
          endcase
          st.res.done_res = st.fin;
        end
        i2cms_pkg::OP_RXBYTE, i2cms_pkg::OP_RXACK: begin
          // release sda, raise scl, then wait for a sample
          st.fin = (phase == 2'd1);
          if (phase == 2'd0) begin
            st.wr_sda = 1'b1;
            st.lvl    = 1'b1;
          end else begin
            st.wr_scl             = 1'b1;
            st.lvl                = 1'b1;
            st.res.sample_request = 1'b1;
            st.ctl_nxt.active_bus = cmd.bus;
            if (op == i2cms_pkg::OP_RXBYTE) begin
              st.ctl_nxt.pending   = i2cms_pkg::PEND_RXBYTE;
              st.ctl_nxt.bit_index = 4'd0;
              st.ctl_nxt.shift_in  = 8'h00;
            end else begin
              st.ctl_nxt.pending = i2cms_pkg::PEND_RXACK;
            end
          end
        end
        i2cms_pkg::OP_SAMPLE: begin
          st.wr_scl = 1'b1;
          if (ctl.pending == i2cms_pkg::PEND_RXACK) begin
            st.lvl              = 1'b0;
            st.res.done_res     = 1'b1;
            st.res.ack_received = cmd.sda_sample;
            st.ctl_nxt.pending  = i2cms_pkg::PEND_NONE;
          end else if (phase == 2'd0) begin
            st.lvl               = 1'b0;
            st.ctl_nxt.bit_index = bi_new;
            st.ctl_nxt.shift_in  = sh_new;
            if (bi_new >= i2cms_pkg::BITS_PER_BYTE) begin
              st.res.done_res    = 1'b1;
              st.res.read_byte   = sh_new;
              st.ctl_nxt.pending = i2cms_pkg::PEND_NONE;
            end else begin
              st.fin = 1'b0;
            end
          end else begin
            st.lvl                = 1'b1;
            st.res.sample_request = 1'b1;
          end
        end
        default: begin
          st.emit = 1'b0;
        end
      endcase
    end

    st.res.bus_out   = st.bus;
    st.res.scl_level = st.wr_scl ? st.lvl : scl_v[st.bus];
    st.res.sda_level = st.wr_sda ? st.lvl : sda_v[st.bus];
    st.res.last      = st.fin;
  end

endmodule

`default_nettype wire
